>>> sv/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and widths for the quaternion vector rotate unit
// Fixed-point formats, product and sum widths, and the payload structs that
// travel between the pipeline stages.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int VEC_W      = 32;               // Q15.16 vector component
	localparam int QUAT_W     = 16;               // Q1.15 quaternion part
	localparam int FRAC_SHIFT = 15;               // Q.31 -> Q.16
	localparam int P1_W       = VEC_W + QUAT_W;   // exact q*v product
	localparam int S1_W       = P1_W + 2;         // sum of three products
	localparam int R_W        = S1_W - FRAC_SHIFT; // intermediate, Q.16
	localparam int P2_W       = R_W + QUAT_W;     // exact r*q product
	localparam int S2_W       = P2_W + 2;         // sum of four products
	localparam int O_W        = S2_W - FRAC_SHIFT; // result before clamp

	localparam int IN_TDATA_W  = 3 * VEC_W + 4 * QUAT_W;
	localparam int OUT_TDATA_W = ((3 * VEC_W + 1 + 7) / 8) * 8;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [QUAT_W-1:0] quat_part_t;
	typedef logic signed [P1_W-1:0]   prod1_t;
	typedef logic signed [R_W-1:0]    rq_t;
	typedef logic signed [P2_W-1:0]   prod2_t;

	typedef struct packed {
		vec_t x;
		vec_t y;
		vec_t z;
	} vec3_t;

	typedef struct packed {
		quat_part_t x;
		quat_part_t y;
		quat_part_t z;
		quat_part_t w;
	} quat_t;

	// First product bank, grouped by intermediate component
	typedef struct packed {
		prod1_t [2:0] rw;
		prod1_t [2:0] rx;
		prod1_t [2:0] ry;
		prod1_t [2:0] rz;
		quat_t        q;
	} p1_bank_t;

	// Rounded intermediate quaternion r = q * v
	typedef struct packed {
		rq_t   w;
		rq_t   x;
		rq_t   y;
		rq_t   z;
		quat_t q;
	} rq_bank_t;

	// Second product bank, four terms per output component
	typedef struct packed {
		prod2_t [3:0] ox;
		prod2_t [3:0] oy;
		prod2_t [3:0] oz;
	} p2_bank_t;

	typedef struct packed {
		vec_t x;
		vec_t y;
		vec_t z;
		logic ovf;
	} res_t;

endpackage

>>> sv/qvr_prod1.sv
// ----------------------------------------------------------------------------
// qvr_prod1: first product bank
// Twelve 16x32 signed products of quaternion and vector, registered.
// ----------------------------------------------------------------------------
module qvr_prod1 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qvr_pkg::vec3_t vec,
	input  qvr_pkg::quat_t quat,
	output logic           out_valid,
	input  logic           out_ready,
	output qvr_pkg::p1_bank_t bank
);
	import qvr_pkg::*;

	logic     valid_s1;
	p1_bank_t bank_s1;

	function automatic prod1_t mul1(input quat_part_t a, input vec_t b);
		mul1 = P1_W'(a) * P1_W'(b);
	endfunction

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// rw = -(qx*vx + qy*vy + qz*vz); rx = qw*vx + qy*vz - qz*vy; etc.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bank_s1.rw[0] <= mul1(quat.x, vec.x);
			bank_s1.rw[1] <= mul1(quat.y, vec.y);
			bank_s1.rw[2] <= mul1(quat.z, vec.z);
			bank_s1.rx[0] <= mul1(quat.w, vec.x);
			bank_s1.rx[1] <= mul1(quat.y, vec.z);
			bank_s1.rx[2] <= mul1(quat.z, vec.y);
			bank_s1.ry[0] <= mul1(quat.w, vec.y);
			bank_s1.ry[1] <= mul1(quat.z, vec.x);
			bank_s1.ry[2] <= mul1(quat.x, vec.z);
			bank_s1.rz[0] <= mul1(quat.w, vec.z);
			bank_s1.rz[1] <= mul1(quat.x, vec.y);
			bank_s1.rz[2] <= mul1(quat.y, vec.x);
			bank_s1.q     <= quat;
		end
	end

	assign out_valid = valid_s1;
	assign bank      = bank_s1;

endmodule

>>> sv/qvr_rsum.sv
// ----------------------------------------------------------------------------
// qvr_rsum: intermediate quaternion sum
// Sums each product triple exactly and rounds Q.31 to Q.16, nearest,
// ties toward plus infinity.
// ----------------------------------------------------------------------------
module qvr_rsum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qvr_pkg::p1_bank_t bank,
	output logic              out_valid,
	input  logic              out_ready,
	output qvr_pkg::rq_bank_t rq
);
	import qvr_pkg::*;

	localparam logic signed [S1_W-1:0] RND = S1_W'(1) <<< (FRAC_SHIFT - 1);

	logic                   valid_s2;
	rq_bank_t               rq_s2;
	logic signed [S1_W-1:0] sum_w, sum_x, sum_y, sum_z;

	function automatic rq_t rnd1(input logic signed [S1_W-1:0] s);
		logic signed [S1_W-1:0] t;
		t    = s + RND;
		rnd1 = t[S1_W-1:FRAC_SHIFT];
	endfunction

	always_comb begin
		sum_w = -(S1_W'(bank.rw[0]) + S1_W'(bank.rw[1]) + S1_W'(bank.rw[2]));
		sum_x = S1_W'(bank.rx[0]) + S1_W'(bank.rx[1]) - S1_W'(bank.rx[2]);
		sum_y = S1_W'(bank.ry[0]) + S1_W'(bank.ry[1]) - S1_W'(bank.ry[2]);
		sum_z = S1_W'(bank.rz[0]) + S1_W'(bank.rz[1]) - S1_W'(bank.rz[2]);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rq_s2.w <= rnd1(sum_w);
			rq_s2.x <= rnd1(sum_x);
			rq_s2.y <= rnd1(sum_y);
			rq_s2.z <= rnd1(sum_z);
			rq_s2.q <= bank.q;
		end
	end

	assign out_valid = valid_s2;
	assign rq        = rq_s2;

endmodule

>>> sv/qvr_prod2.sv
// ----------------------------------------------------------------------------
// qvr_prod2: second product bank
// Twelve 35x16 signed products of the intermediate with the quaternion.
// ----------------------------------------------------------------------------
module qvr_prod2 (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qvr_pkg::rq_bank_t rq,
	output logic              out_valid,
	input  logic              out_ready,
	output qvr_pkg::p2_bank_t bank
);
	import qvr_pkg::*;

	logic     valid_s3;
	p2_bank_t bank_s3;

	function automatic prod2_t mul2(input rq_t a, input quat_part_t b);
		mul2 = P2_W'(a) * P2_W'(b);
	endfunction

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// term order per component: -, +, -, +
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bank_s3.ox[0] <= mul2(rq.w, rq.q.x);
			bank_s3.ox[1] <= mul2(rq.x, rq.q.w);
			bank_s3.ox[2] <= mul2(rq.y, rq.q.z);
			bank_s3.ox[3] <= mul2(rq.z, rq.q.y);
			bank_s3.oy[0] <= mul2(rq.w, rq.q.y);
			bank_s3.oy[1] <= mul2(rq.y, rq.q.w);
			bank_s3.oy[2] <= mul2(rq.z, rq.q.x);
			bank_s3.oy[3] <= mul2(rq.x, rq.q.z);
			bank_s3.oz[0] <= mul2(rq.w, rq.q.z);
			bank_s3.oz[1] <= mul2(rq.z, rq.q.w);
			bank_s3.oz[2] <= mul2(rq.x, rq.q.y);
			bank_s3.oz[3] <= mul2(rq.y, rq.q.x);
		end
	end

	assign out_valid = valid_s3;
	assign bank      = bank_s3;

endmodule

>>> sv/qvr_out.sv
// ----------------------------------------------------------------------------
// qvr_out: output sum, rounding and saturation
// Sums the four terms per component, rounds to Q.16, clamps to 32 bits and
// holds the result beat in the output register.
// ----------------------------------------------------------------------------
module qvr_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qvr_pkg::p2_bank_t bank,
	output logic              out_valid,
	input  logic              out_ready,
	output qvr_pkg::res_t     res
);
	import qvr_pkg::*;

	localparam logic signed [S2_W-1:0] RND = S2_W'(1) <<< (FRAC_SHIFT - 1);

	logic                   valid_s4;
	res_t                   res_s4;
	logic signed [S2_W-1:0] sum_x, sum_y, sum_z;
	logic signed [O_W-1:0]  o_x, o_y, o_z;
	logic                   ovf_x, ovf_y, ovf_z;

	function automatic logic signed [O_W-1:0] rnd2(input logic signed [S2_W-1:0] s);
		logic signed [S2_W-1:0] t;
		t    = s + RND;
		rnd2 = t[S2_W-1:FRAC_SHIFT];
	endfunction

	// upper bits must all match the sign of the 32-bit result
	function automatic logic out_of_range(input logic signed [O_W-1:0] v);
		out_of_range = (v[O_W-1:VEC_W-1] != '0) && (v[O_W-1:VEC_W-1] != '1);
	endfunction

	function automatic vec_t clamp(input logic signed [O_W-1:0] v);
		if (!out_of_range(v)) begin
			clamp = v[VEC_W-1:0];
		end else if (v[O_W-1]) begin
			clamp = {1'b1, {(VEC_W-1){1'b0}}};
		end else begin
			clamp = {1'b0, {(VEC_W-1){1'b1}}};
		end
	endfunction

	always_comb begin
		sum_x = -S2_W'(bank.ox[0]) + S2_W'(bank.ox[1]) - S2_W'(bank.ox[2])
			+ S2_W'(bank.ox[3]);
		sum_y = -S2_W'(bank.oy[0]) + S2_W'(bank.oy[1]) - S2_W'(bank.oy[2])
			+ S2_W'(bank.oy[3]);
		sum_z = -S2_W'(bank.oz[0]) + S2_W'(bank.oz[1]) - S2_W'(bank.oz[2])
			+ S2_W'(bank.oz[3]);
		o_x   = rnd2(sum_x);
		o_y   = rnd2(sum_y);
		o_z   = rnd2(sum_z);
		ovf_x = out_of_range(o_x);
		ovf_y = out_of_range(o_y);
		ovf_z = out_of_range(o_z);
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_s4.x   <= clamp(o_x);
			res_s4.y   <= clamp(o_y);
			res_s4.z   <= clamp(o_z);
			res_s4.ovf <= ovf_x || ovf_y || ovf_z;
		end
	end

	assign out_valid = valid_s4;
	assign res       = res_s4;

endmodule

>>> sv/quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit: fixed-point rotation of a vector by a quaternion
// Computes r = q * v, then combines r with q again, rounding each step to
// Q.16 and saturating the result to 32 bits with an overflow flag.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat contents (tdata, low bits first)
// s_axis    in   vec_x[31:0] vec_y[63:32] vec_z[95:64] quat_x[111:96]
//                quat_y[127:112] quat_z[143:128] quat_w[159:144]
// m_axis    out  rot_x[31:0] rot_y[63:32] rot_z[95:64] overflow[96], 0 pad
//
// One beat in and one beat out per cycle, sustained while m_axis_tready
// stays high. Four register stages: the first product bank, intermediate
// sum/round, second product bank, and the final sum/round/clamp into the
// output reg.
// Each stage loads whenever it is empty or its successor moves, so bubbles
// collapse and backpressure on m_axis_tready stalls the chain without loss.
// arst_n clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w
	input  logic [qvr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// rot_x, rot_y, rot_z, overflow, zero pad
	output logic [qvr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import qvr_pkg::*;

	vec3_t    vec_in;
	quat_t    quat_in;
	p1_bank_t bank1;
	rq_bank_t rq;
	p2_bank_t bank2;
	res_t     res;

	// stage handshake: v_N is the valid out of stage N, r_N its ready in
	logic v1, v2, v3;
	logic r2, r3, r4;

	// unpack the input beat
	assign vec_in.x  = s_axis_tdata[VEC_W-1:0];
	assign vec_in.y  = s_axis_tdata[2*VEC_W-1:VEC_W];
	assign vec_in.z  = s_axis_tdata[3*VEC_W-1:2*VEC_W];
	assign quat_in.x = s_axis_tdata[3*VEC_W+QUAT_W-1:3*VEC_W];
	assign quat_in.y = s_axis_tdata[3*VEC_W+2*QUAT_W-1:3*VEC_W+QUAT_W];
	assign quat_in.z = s_axis_tdata[3*VEC_W+3*QUAT_W-1:3*VEC_W+2*QUAT_W];
	assign quat_in.w = s_axis_tdata[3*VEC_W+4*QUAT_W-1:3*VEC_W+3*QUAT_W];

	// stage 1: q * v products
	qvr_prod1 u_prod1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.vec       (vec_in),
		.quat      (quat_in),
		.out_valid (v1),
		.out_ready (r2),
		.bank      (bank1)
	);

	// stage 2: intermediate quaternion, rounded to Q.16, never clamped
	qvr_rsum u_rsum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2),
		.bank      (bank1),
		.out_valid (v2),
		.out_ready (r3),
		.rq        (rq)
	);

	// stage 3: r * q products
	qvr_prod2 u_prod2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r3),
		.rq        (rq),
		.out_valid (v3),
		.out_ready (r4),
		.bank      (bank2)
	);

	// stage 4: final sum, round, clamp; this register drives m_axis
	qvr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3),
		.in_ready  (r4),
		.bank      (bank2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	// pack the output beat
	assign m_axis_tdata = {{(OUT_TDATA_W - 3*VEC_W - 1){1'b0}},
		res.ovf, res.z, res.y, res.x};

endmodule

>>> sv/qvr_checker.sv
// ----------------------------------------------------------------------------
// qvr_checker: port-level checks for the quaternion vector rotate unit
// Watches both stream ports: result hold under stall, overflow coding and
// pipeline latency with an open sink.
// ----------------------------------------------------------------------------
module qvr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [qvr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import qvr_pkg::*;

	localparam logic [VEC_W-1:0] POS_MAX = {1'b0, {(VEC_W-1){1'b1}}};
	localparam logic [VEC_W-1:0] NEG_MAX = {1'b1, {(VEC_W-1){1'b0}}};

	logic [VEC_W-1:0] rx, ry, rz;
	logic             s_beat;

	assign rx     = m_axis_tdata[VEC_W-1:0];
	assign ry     = m_axis_tdata[2*VEC_W-1:VEC_W];
	assign rz     = m_axis_tdata[3*VEC_W-1:2*VEC_W];
	assign s_beat = s_axis_tvalid && s_axis_tready;

	// a stalled result beat stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

	// overflow only with a component pinned at a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3*VEC_W] |->
			(rx == POS_MAX || rx == NEG_MAX || ry == POS_MAX || ry == NEG_MAX
			|| rz == POS_MAX || rz == NEG_MAX))
		else $error("overflow flag without a saturated component");

	// with the sink open, an accepted beat reaches m_axis_tvalid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
			|=> m_axis_tvalid)
		else $error("result missing after pipeline latency");

endmodule

bind quaternion_vector_rotate_unit qvr_checker u_qvr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> test/quaternion_vector_rotate_unit_tb.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit_tb: self-checking bench for the rotate unit
// Streams vector/quaternion beats through the unit and predicts each rotated
// vector in fixed point. The predictor rounds both product stages to Q.16 and
// saturates to 32 bits with an overflow flag. A short directed table of
// identity, half-turn, rounding and saturation cases comes first. Random
// beats follow. Both stream sides idle at random, and one long output stall
// backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qvr_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1032;
	localparam int CALM_FROM    = 300;      // random beats with no idling on either side
	localparam int CALM_TO      = 420;
	localparam int HOLD_AT      = 250;      // results seen before the long output stall
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 12;       // pipeline is four deep
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_MAX   = 10;

	localparam vec_t       VMAX  = 32'sh7FFF_FFFF;
	localparam vec_t       VMIN  = 32'sh8000_0000;
	localparam quat_part_t QMAX  = 16'sh7FFF;
	localparam quat_part_t QNEG1 = 16'sh8000;  // -1.0, the only way to spell a unit part
	localparam quat_part_t QHALF = 16'sh4000;
	localparam longint     SAT_HI = 64'sd2147483647;
	localparam longint     SAT_LO = -64'sd2147483648;

	typedef enum {SHAPE_FULL, SHAPE_SMALL, SHAPE_NEAR_UNIT, SHAPE_EDGE} shape_t;

	typedef struct {
		vec3_t v;
		quat_t q;
		bit    typed;   // want holds a hand-derived result
		res_t  want;
	} stim_row_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	res_t      rot_pending[$];   // expected rotations, oldest first
	stim_row_t dir_rows[$];
	int        mismatches    = 0;
	int        rot_checked   = 0;
	int        rot_saturated = 0;
	int        cycle_count   = 0;
	bit        calm          = 1'b0;

	quaternion_vector_rotate_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// --- prediction ---------------------------------------------------------

	// Q.31 -> Q.16, nearest with ties upward: floor((x + 2^14) / 2^15)
	function automatic longint round_q16(longint x);
		return (x + 64'sd16384) >>> 15;
	endfunction

	function automatic vec_t clamp32(longint x, inout logic ovf);
		if (x > SAT_HI) begin
			ovf = 1'b1;
			return VMAX;
		end
		if (x < SAT_LO) begin
			ovf = 1'b1;
			return VMIN;
		end
		return vec_t'(x);
	endfunction

	// r = q * v, then r combined with q again; quaternion used unnormalized
	function automatic res_t rotate_by_quat(vec3_t v, quat_t q);
		longint vx, vy, vz, qx, qy, qz, qw;
		longint rw, rx, ry, rz;
		res_t   r;
		vx = v.x;
		vy = v.y;
		vz = v.z;
		qx = q.x;
		qy = q.y;
		qz = q.z;
		qw = q.w;
		rw = round_q16(-qx * vx - qy * vy - qz * vz);
		rx = round_q16(qw * vx + qy * vz - qz * vy);
		ry = round_q16(qw * vy + qz * vx - qx * vz);
		rz = round_q16(qw * vz + qx * vy - qy * vx);
		r.ovf = 1'b0;
		r.x = clamp32(round_q16(-rw * qx + rx * qw - ry * qz + rz * qy), r.ovf);
		r.y = clamp32(round_q16(-rw * qy + ry * qw - rz * qx + rx * qz), r.ovf);
		r.z = clamp32(round_q16(-rw * qz + rz * qw - rx * qy + ry * qx), r.ovf);
		return r;
	endfunction

	// --- stimulus helpers ---------------------------------------------------

	function automatic void add_row(input vec_t vx, vy, vz, input quat_part_t qx, qy, qz, qw,
			input bit typed = 1'b0, input vec_t ex = '0, ey = '0, ez = '0,
			input logic eo = 1'b0);
		stim_row_t row;
		row.v     = '{x: vx, y: vy, z: vz};
		row.q     = '{x: qx, y: qy, z: qz, w: qw};
		row.typed = typed;
		row.want  = '{x: ex, y: ey, z: ez, ovf: eo};
		dir_rows.push_back(row);
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 93)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic vec_t small_vec();
		return vec_t'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
	endfunction

	function automatic vec_t edge_vec();
		case ($urandom_range(0, 5))
			0: return VMIN;
			1: return VMAX;
			2: return '0;
			3: return -32'sd1;
			4: return 32'sd1;
			default: return vec_t'($urandom);
		endcase
	endfunction

	function automatic quat_part_t edge_quat();
		case ($urandom_range(0, 5))
			0: return QNEG1;
			1: return QMAX;
			2: return '0;
			3: return -16'sd1;
			4: return QHALF;
			default: return quat_part_t'($urandom);
		endcase
	endfunction

	function automatic quat_part_t near_unit_quat();
		return quat_part_t'(int'($urandom_range(0, 32766)) - 16383);
	endfunction

	function automatic void random_item(output vec3_t v, output quat_t q);
		shape_t shape;
		int     pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			shape = SHAPE_FULL;
		else if (pick < 7)
			shape = SHAPE_SMALL;
		else if (pick < 9)
			shape = SHAPE_NEAR_UNIT;
		else
			shape = SHAPE_EDGE;
		v.x = vec_t'($urandom);
		v.y = vec_t'($urandom);
		v.z = vec_t'($urandom);
		q.x = quat_part_t'($urandom);
		q.y = quat_part_t'($urandom);
		q.z = quat_part_t'($urandom);
		q.w = quat_part_t'($urandom);
		case (shape)
			SHAPE_SMALL: begin
				v.x = small_vec();
				v.y = small_vec();
				v.z = small_vec();
			end
			SHAPE_NEAR_UNIT: begin
				q.x = near_unit_quat();
				q.y = near_unit_quat();
				q.z = near_unit_quat();
				q.w = near_unit_quat();
			end
			SHAPE_EDGE: begin
				v.x = edge_vec();
				v.y = edge_vec();
				v.z = edge_vec();
				q.x = edge_quat();
				q.y = edge_quat();
				q.z = edge_quat();
				q.w = edge_quat();
			end
			default: ;
		endcase
	endfunction

	// Offer one input beat; the expectation is queued at the accepting edge.
	task automatic send_item(input vec3_t v, input quat_t q, input bit typed, input res_t want);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {q.w, q.z, q.y, q.x, v.z, v.y, v.x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		rot_pending.push_back(typed ? want : rotate_by_quat(v, q));
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			// junk on tdata while tvalid is low must be ignored
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// --- checking -----------------------------------------------------------

	function automatic void flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("[%0t] mismatch %0d on result %0d: %s", $time, mismatches, rot_checked, msg);
	endfunction

	function automatic void check_comp(string name, vec_t exp_v, vec_t got_v);
		if (got_v !== exp_v)
			flag_mismatch($sformatf("%s expected %h got %h", name, exp_v, got_v));
	endfunction

	always @(posedge clk) begin : out_monitor
		res_t want;
		vec_t got_x, got_y, got_z;
		logic got_ovf;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_x   = m_axis_tdata[VEC_W-1:0];
			got_y   = m_axis_tdata[2*VEC_W-1:VEC_W];
			got_z   = m_axis_tdata[3*VEC_W-1:2*VEC_W];
			got_ovf = m_axis_tdata[3*VEC_W];
			if (rot_pending.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
			end else begin
				want = rot_pending.pop_front();
				check_comp("rot_x", want.x, got_x);
				check_comp("rot_y", want.y, got_y);
				check_comp("rot_z", want.z, got_z);
				if (got_ovf !== want.ovf)
					flag_mismatch($sformatf("overflow expected %b got %b", want.ovf, got_ovf));
				if (m_axis_tdata[OUT_TDATA_W-1:3*VEC_W+1] !== '0)
					flag_mismatch($sformatf("pad bits not zero: %h",
						m_axis_tdata[OUT_TDATA_W-1:3*VEC_W+1]));
			end
			rot_checked++;
			if (got_ovf === 1'b1)
				rot_saturated++;
		end
	end

	// --- output pacing: random stalls plus one long hold-off ---------------

	initial begin : out_pacing
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && rot_checked >= HOLD_AT) begin
				// input keeps offering meanwhile, so the pipe fills and tready drops
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm)
					stall_left = idle_len();
			end
		end
	end

	// --- watchdog -----------------------------------------------------------

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_count, rot_pending.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// --- main sequence ------------------------------------------------------

	initial begin : stimulus
		vec3_t v;
		quat_t q;

		// zero quaternion kills any vector
		add_row('0, '0, '0, '0, '0, '0, '0, 1'b1, '0, '0, '0, 1'b0);
		add_row(VMAX, VMIN, 32'sd1, '0, '0, '0, '0, 1'b1, '0, '0, '0, 1'b0);
		// w = -1.0 is the identity rotation, exact even at the extremes
		add_row(VMAX, VMIN, -32'sd1, '0, '0, '0, QNEG1, 1'b1, VMAX, VMIN, -32'sd1, 1'b0);
		add_row(32'sd1, 32'sh0001_0000, -32'sh0001_0000, '0, '0, '0, QNEG1,
			1'b1, 32'sd1, 32'sh0001_0000, -32'sh0001_0000, 1'b0);
		// half turn about x: (x, -y, -z)
		add_row(32'sh0005_0000, 32'shFFF9_0000, 32'sd3, QNEG1, '0, '0, '0,
			1'b1, 32'sh0005_0000, 32'sh0007_0000, -32'sd3, 1'b0);
		// negating the most negative y clamps high
		add_row(VMIN, VMIN, VMAX, QNEG1, '0, '0, '0, 1'b1, VMIN, VMAX, -VMAX, 1'b1);
		// half turn about y: (-x, y, -z)
		add_row(VMIN, 32'sd12345, -32'sd1, '0, QNEG1, '0, '0,
			1'b1, VMAX, 32'sd12345, 32'sd1, 1'b1);
		// half turn about z: (-x, -y, z)
		add_row(VMIN, VMIN, VMIN, '0, '0, QNEG1, '0, 1'b1, VMAX, VMAX, VMIN, 1'b1);
		// rounding ties through both stages at half scale
		add_row(32'sd1, -32'sd1, 32'sd3, '0, '0, '0, QHALF);
		add_row(-32'sd3, 32'sd2, -32'sd2, '0, '0, '0, QHALF);
		add_row(VMAX, VMAX, VMAX, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
		add_row(VMAX, 32'sd0, 32'sd0, 16'sd1, '0, '0, '0);
		// |q|^2 = 4: every full-scale component blows up
		add_row(VMAX, VMAX, VMAX, QNEG1, QNEG1, QNEG1, QNEG1);
		add_row(VMIN, VMIN, VMIN, QNEG1, QNEG1, QNEG1, QNEG1);
		add_row(VMIN, VMAX, VMIN, QMAX, QMAX, QMAX, QMAX);
		add_row(-32'sd1, -32'sd1, -32'sd1, QMAX, QMAX, QMAX, QMAX);
		// scaled rotation that clamps low
		add_row(VMIN, '0, '0, QNEG1, '0, '0, QNEG1);
		add_row(VMAX, VMIN, 32'sh5555_AAAA, '0, '0, '0, QMAX);
		add_row(32'sh1234_5678, -32'sh0FED_CBA9, 32'sh0001_0000, QMAX, QNEG1, QMAX, QNEG1);

		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].v, dir_rows[i].q, dir_rows[i].typed, dir_rows[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= CALM_FROM) && (n < CALM_TO);
			random_item(v, q);
			send_item(v, q, 1'b0, '0);
		end
		calm = 1'b0;

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (rot_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Rotated %0d vectors (%0d from the directed table), %0d of them clamped.",
			rot_checked, dir_rows.size(), rot_saturated);
		$display("Output held off once for %0d cycles; %0d mismatches in %0d cycles.",
			HOLD_CYCLES, mismatches, cycle_count);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
sv/qvr_pkg.sv
sv/qvr_prod1.sv
sv/qvr_rsum.sv
sv/qvr_prod2.sv
sv/qvr_out.sv
sv/quaternion_vector_rotate_unit.sv
sv/qvr_checker.sv
test/quaternion_vector_rotate_unit_tb.sv
